[sv/key_light_direction_rotator_macros.svh]
// Assertion macros shared by the key-light rotator checker.
`ifndef KEY_LIGHT_DIRECTION_ROTATOR_MACROS_SVH
`define KEY_LIGHT_DIRECTION_ROTATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KLDR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KLDR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/kldr_pkg.sv]
// Shared constants, types and rounding helpers of the key-light rotator.
`default_nettype none

package kldr_pkg;

  localparam int unsigned CORDIC_STAGES_DEF = 16;
  localparam int unsigned OUT_FRAC_BITS_DEF = 14;

  localparam int unsigned ANG_W  = 37;   // angle in Q30 radians, wide enough for tilt
  localparam int unsigned RED_W  = 38;   // range reduction candidates
  localparam int unsigned Z_W    = 34;   // CORDIC residual angle
  localparam int unsigned TRIG_W = 32;   // CORDIC x and y
  localparam int unsigned DIV_BITS = 19; // quotient bits of the weight divider
  localparam int unsigned DIV_STAGES = 3; // reciprocal estimate, remainder, correction
  localparam int unsigned DIV_W  = 50;
  localparam int unsigned LAT_FIXED = DIV_STAGES + 11;

  localparam logic signed [Z_W-1:0] PI_Z      = 34'sd3373259426;
  localparam logic signed [Z_W-1:0] HALF_PI_Z = 34'sd1686629713;
  localparam logic [DIV_W-1:0]      HALF_PI_U = 50'd1686629713;
  localparam logic [DIV_W-1:0]      QTR_PI_U  = 50'd843314856;
  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 32'sd652032874;

  // floor(2^52 / half pi in Q30), applied to the numerator above bit 30.
  localparam logic [21:0]           RECIP_HPI    = 22'd2670176;
  localparam int unsigned           RECIP_HPI_SH = 22;

  // Degrees Q9.7 to radians Q30: pi/23040 split into integer and remainder parts.
  localparam logic [34:0] DEG_K_INT    = 35'd146408;
  localparam logic [31:0] DEG_K_REM    = 32'd19106;
  localparam logic [31:0] DEG_HALF_DEN = 32'd11520;
  localparam logic [45:0] RECIP_45     = 46'd5965233;
  localparam int unsigned RECIP_SH     = 28;

  localparam int unsigned RED_N = 7;
  localparam logic signed [RED_W-1:0] RED_OFS [RED_N] = '{
    38'sd20239556556, 38'sd13493037704, 38'sd6746518852, 38'sd0,
    -38'sd6746518852, -38'sd13493037704, -38'sd20239556556
  };

  localparam logic [31:0] ATAN_TAB [24] = '{
    32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158,
    32'd67021686,  32'd33543515,  32'd16775850,  32'd8388437,
    32'd4194282,   32'd2097149,   32'd1048575,   32'd524287,
    32'd262143,    32'd131071,    32'd65535,     32'd32767,
    32'd16383,     32'd8191,      32'd4095,      32'd2047,
    32'd1023,      32'd511,       32'd255,       32'd127
  };

  typedef enum logic [1:0] {
    CFG_RIG_HEADING  = 2'd0,
    CFG_HORIZON_TILT = 2'd1,
    CFG_MIDDAY_TILT  = 2'd2
  } cfg_idx_e;

  // Round to nearest, ties away from zero.
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                   input int unsigned s);
    logic signed [63:0] bias;
    if (s == 0) return v;
    bias = 64'sd1 <<< (s - 1);
    if (v < 0) bias = bias - 64'sd1;
    return (v + bias) >>> s;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    if (v > 64'sd32767) return 16'sh7fff;
    if (v < -64'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

endpackage

`default_nettype wire

[sv/key_light_direction_rotator.sv]
// Top level of the key-light direction rotator.
//
// Usage: raise start with a sun angle on sun_angle_i (unsigned Q3.13 radians);
// the angle is taken at a clock edge where start is high and busy is low. busy
// stays low, so a new angle can be taken on every cycle. One transaction in
// gives one result out: dir_x_o, dir_y_o and dir_z_o (signed, OUT_FRAC_BITS
// fraction bits, saturated to 16 bits) are shown for one cycle with done_o.
// The receiver cannot stall; a result is taken in the cycle it is shown.
// The pipeline runs through the input and numerator registers, the ramp weight
// division (reciprocal estimate, remainder, correction), the tilt blend product
// and sum, the range reduction, quadrant fold, CORDIC cell chain and trig output
// registers, and four rotation stages.
// Throughput is one transaction per cycle, set by the fully pipelined cells.
// Configuration: cfg_we_i with cfg_idx_i and cfg_wdata_i writes one register
// (rig heading Q9.7, horizon tilt Q7.7, midday tilt Q7.7, all degrees); other
// indexes are dropped. Write only while no transaction is in flight; the degree
// to radian conversion settles through its product, quotient and result registers.
// Reset clears the configuration to zero and drops every transaction in flight.
`default_nettype none

module key_light_direction_rotator import kldr_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = CORDIC_STAGES_DEF,
  parameter int unsigned OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [15:0]        sun_angle_i,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [16:0]        cfg_wdata_i,
  output logic                    done_o,
  output logic signed [15:0]      dir_x_o,
  output logic signed [15:0]      dir_y_o,
  output logic signed [15:0]      dir_z_o
);

  localparam int unsigned LAT   = LAT_FIXED + CORDIC_STAGES;
  localparam int unsigned FS    = 60 - OUT_FRAC_BITS;
  localparam int unsigned FS_TY = 30 - OUT_FRAC_BITS;

  // Configuration registers, written straight from the port.
  logic signed [16:0] rig_q;
  logic signed [14:0] hor_q, mid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rig_q <= '0;
      hor_q <= '0;
      mid_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_RIG_HEADING:  rig_q <= cfg_wdata_i;
        CFG_HORIZON_TILT: hor_q <= cfg_wdata_i[14:0];
        CFG_MIDDAY_TILT:  mid_q <= cfg_wdata_i[14:0];
        default: ;
      endcase
    end
  end

  // Degrees to Q30 radians: |deg|*146408 + floor((|deg|*19106 + 11520) / 23040),
  // the division being a shift by 9 and a reciprocal multiply for 45.
  logic signed [16:0] deg [3];
  logic [16:0]        mag [3];
  logic               neg1_q [3], neg2_q [3];
  logic [34:0]        p1_q [3], p2_q [3];
  logic [31:0]        v_q [3];
  logic [17:0]        q2_q [3];
  logic signed [ANG_W-1:0] rad_q [3];
  logic [45:0]        recip [3];
  logic [35:0]        rsum [3];

  assign deg[0] = rig_q;
  assign deg[1] = 17'(hor_q);
  assign deg[2] = 17'(mid_q);

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      mag[j]   = deg[j][16] ? 17'(-deg[j]) : 17'(deg[j]);
      recip[j] = 46'(v_q[j][31:9]) * RECIP_45;
      rsum[j]  = 36'(p2_q[j]) + 36'(q2_q[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      neg1_q[j] <= deg[j][16];
      p1_q[j]   <= 35'(mag[j]) * DEG_K_INT;
      v_q[j]    <= 32'(mag[j]) * DEG_K_REM + DEG_HALF_DEN;
      neg2_q[j] <= neg1_q[j];
      p2_q[j]   <= p1_q[j];
      q2_q[j]   <= recip[j][RECIP_SH+17:RECIP_SH];
      rad_q[j]  <= neg2_q[j] ? -$signed(ANG_W'(rsum[j])) : $signed(ANG_W'(rsum[j]));
    end
  end

  // Transaction tracking: one valid bit per pipeline stage.
  logic [LAT-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], start & ~busy};
    end
  end

  assign busy   = 1'b0;
  assign done_o = vld_q[LAT-1];

  // Tilt blend, then three trig chains in lockstep.
  logic signed [ANG_W-1:0] tilt;
  logic [15:0]             sun_t;

  kldr_tilt u_tilt (
    .clk_i  (clk_i),
    .sun_i  (sun_angle_i),
    .h_rad_i(rad_q[1]),
    .m_rad_i(rad_q[2]),
    .tilt_o (tilt),
    .sun_o  (sun_t)
  );

  logic signed [TRIG_W-1:0] sa, ca, st, ct, sr, cr;

  kldr_cordic #(.STAGES(CORDIC_STAGES)) u_trig_sun (
    .clk_i(clk_i),
    .ang_i($signed({4'b0, sun_t, 17'b0})),
    .sin_o(sa),
    .cos_o(ca)
  );

  kldr_cordic #(.STAGES(CORDIC_STAGES)) u_trig_tilt (
    .clk_i(clk_i),
    .ang_i(tilt),
    .sin_o(st),
    .cos_o(ct)
  );

  kldr_cordic #(.STAGES(CORDIC_STAGES)) u_trig_rig (
    .clk_i(clk_i),
    .ang_i(rad_q[0]),
    .sin_o(sr),
    .cos_o(cr)
  );

  // Rotate (-cos a, -sin a, 0) about X by the tilt, then about Y by the heading.
  logic signed [TRIG_W-1:0] bx1_q, bx2_q, sr1_q, cr1_q, sr2_q, cr2_q;
  logic signed [TRIG_W-1:0] ty2_q, tz2_q, ty3_q;
  logic signed [63:0]       pty_q, ptz_q, m1_q, m2_q, m3_q, m4_q;
  logic signed [TRIG_W-1:0] by;

  assign by = -sa;

  always_ff @(posedge clk_i) begin
    bx1_q   <= -ca;
    sr1_q   <= sr;
    cr1_q   <= cr;
    pty_q   <= 64'(by) * 64'(ct);
    ptz_q   <= 64'(by) * 64'(st);
    bx2_q   <= bx1_q;
    sr2_q   <= sr1_q;
    cr2_q   <= cr1_q;
    ty2_q   <= TRIG_W'(rnd_shift(pty_q, 30));
    tz2_q   <= TRIG_W'(rnd_shift(-ptz_q, 30));
    ty3_q   <= ty2_q;
    m1_q    <= 64'(bx2_q) * 64'(cr2_q);
    m2_q    <= 64'(tz2_q) * 64'(sr2_q);
    m3_q    <= 64'(bx2_q) * 64'(sr2_q);
    m4_q    <= 64'(tz2_q) * 64'(cr2_q);
    dir_x_o <= sat16(rnd_shift(m1_q - m2_q, FS));
    dir_y_o <= sat16(rnd_shift(64'(ty3_q), FS_TY));
    dir_z_o <= sat16(rnd_shift(m3_q + m4_q, FS));
  end

endmodule

`default_nettype wire

[sv/kldr_cordic_cell.sv]
// One rotation-mode CORDIC cell with its output registers.
`default_nettype none

module kldr_cordic_cell import kldr_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  wire logic                     clk_i,
  input  wire logic signed [TRIG_W-1:0] x_i,
  input  wire logic signed [TRIG_W-1:0] y_i,
  input  wire logic signed [Z_W-1:0]    z_i,
  input  wire logic                     flip_i,
  output logic signed [TRIG_W-1:0]      x_o,
  output logic signed [TRIG_W-1:0]      y_o,
  output logic signed [Z_W-1:0]         z_o,
  output logic                          flip_o
);

  localparam logic signed [Z_W-1:0] ATAN_K = Z_W'(ATAN_TAB[IDX]);

  logic signed [TRIG_W-1:0] x_d, y_d;
  logic signed [Z_W-1:0]    z_d;

  always_comb begin
    if (z_i >= 0) begin
      x_d = x_i - (y_i >>> IDX);
      y_d = y_i + (x_i >>> IDX);
      z_d = z_i - ATAN_K;
    end else begin
      x_d = x_i + (y_i >>> IDX);
      y_d = y_i - (x_i >>> IDX);
      z_d = z_i + ATAN_K;
    end
  end

  always_ff @(posedge clk_i) begin
    x_o    <= x_d;
    y_o    <= y_d;
    z_o    <= z_d;
    flip_o <= flip_i;
  end

endmodule

`default_nettype wire

[sv/kldr_cordic.sv]
// Sine and cosine: range reduction, quadrant fold and a chain of CORDIC cells.
`default_nettype none

module kldr_cordic import kldr_pkg::*; #(
  parameter int unsigned STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic signed [ANG_W-1:0]  ang_i,
  output logic signed [TRIG_W-1:0]      sin_o,
  output logic signed [TRIG_W-1:0]      cos_o
);

  logic signed [Z_W-1:0] t_d, t_q, z0_d, z0_q;
  logic                  flip0_d, flip0_q;
  logic signed [RED_W-1:0] cand;

  // Reduce into [-pi, pi): within 3.5 turns, exactly one offset lands there.
  always_comb begin
    t_d  = '0;
    cand = '0;
    for (int j = 0; j < RED_N; j++) begin
      cand = RED_W'(ang_i) + RED_OFS[j];
      if (cand >= -RED_W'(PI_Z) && cand < RED_W'(PI_Z)) t_d = cand[Z_W-1:0];
    end
  end

  // Fold into [-pi/2, pi/2]; a step of pi negates both results.
  always_comb begin
    z0_d    = t_q;
    flip0_d = 1'b0;
    if (t_q > HALF_PI_Z) begin
      z0_d    = t_q - PI_Z;
      flip0_d = 1'b1;
    end else if (t_q < -HALF_PI_Z) begin
      z0_d    = t_q + PI_Z;
      flip0_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q     <= t_d;
    z0_q    <= z0_d;
    flip0_q <= flip0_d;
  end

  logic signed [TRIG_W-1:0] x_w [STAGES];
  logic signed [TRIG_W-1:0] y_w [STAGES];
  logic signed [Z_W-1:0]    z_w [STAGES];
  logic                     f_w [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_cell
    if (k == 0) begin : g_first
      kldr_cordic_cell #(.IDX(k)) u_cell (
        .clk_i (clk_i),
        .x_i   (CORDIC_GAIN),
        .y_i   ('0),
        .z_i   (z0_q),
        .flip_i(flip0_q),
        .x_o   (x_w[k]),
        .y_o   (y_w[k]),
        .z_o   (z_w[k]),
        .flip_o(f_w[k])
      );
    end else begin : g_next
      kldr_cordic_cell #(.IDX(k)) u_cell (
        .clk_i (clk_i),
        .x_i   (x_w[k-1]),
        .y_i   (y_w[k-1]),
        .z_i   (z_w[k-1]),
        .flip_i(f_w[k-1]),
        .x_o   (x_w[k]),
        .y_o   (y_w[k]),
        .z_o   (z_w[k]),
        .flip_o(f_w[k])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    sin_o <= f_w[STAGES-1] ? -y_w[STAGES-1] : y_w[STAGES-1];
    cos_o <= f_w[STAGES-1] ? -x_w[STAGES-1] : x_w[STAGES-1];
  end

endmodule

`default_nettype wire

[sv/kldr_tilt.sv]
// Ramp weight by reciprocal division by half pi, then the blended tilt angle.
`default_nettype none

module kldr_tilt import kldr_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic [15:0]             sun_i,
  input  wire logic signed [ANG_W-1:0] h_rad_i,
  input  wire logic signed [ANG_W-1:0] m_rad_i,
  output logic signed [ANG_W-1:0]      tilt_o,
  output logic [15:0]                  sun_o
);

  localparam int unsigned PROD_W = ANG_W + 21;
  localparam int unsigned REM_W  = 34;

  logic [15:0]      sun0_q, sun1_q, sun2_q, sun3_q, sun4_q;
  logic [DIV_W-1:0] num_d, num_q, num2_q;
  logic signed [33:0] diff_a;
  logic [32:0]      dabs;

  always_comb begin
    diff_a = $signed({1'b0, sun0_q, 17'b0}) - 34'sd1686629713;
    dabs   = diff_a[33] ? 33'(-diff_a) : diff_a[32:0];
    num_d  = DIV_W'({dabs, 16'b0}) + QTR_PI_U;
  end

  always_ff @(posedge clk_i) begin
    sun0_q <= sun_i;
    sun1_q <= sun0_q;
    num_q  <= num_d;
  end

  // Divide by half pi: a reciprocal estimate from the upper numerator bits,
  // which never overshoots and falls short by at most one, then the remainder
  // and a compare and increment to settle the last step.
  logic [41:0]         qmul;
  logic [DIV_W-1:0]    qd;
  logic [REM_W-1:0]    rem_d, rem_q;
  logic [DIV_BITS-1:0] qe_q, qe2_q, quo_d, quo_q;

  assign qmul  = 42'(num_q[DIV_W-1:30]) * 42'(RECIP_HPI);
  assign qd    = DIV_W'(qe_q) * HALF_PI_U;
  assign rem_d = REM_W'(num2_q - qd);

  always_comb begin
    quo_d = qe2_q;
    if (DIV_W'(rem_q) >= (HALF_PI_U << 1)) quo_d = qe2_q + DIV_BITS'(2);
    else if (DIV_W'(rem_q) >= HALF_PI_U) quo_d = qe2_q + DIV_BITS'(1);
  end

  always_ff @(posedge clk_i) begin
    qe_q   <= qmul[RECIP_HPI_SH+DIV_BITS-1:RECIP_HPI_SH];
    num2_q <= num_q;
    sun2_q <= sun1_q;
    rem_q  <= rem_d;
    qe2_q  <= qe_q;
    sun3_q <= sun2_q;
    quo_q  <= quo_d;
    sun4_q <= sun3_q;
  end

  logic signed [19:0]       w;
  logic signed [ANG_W:0]    span;
  logic signed [PROD_W-1:0] prod_q;
  logic [15:0]              sunp_q;

  assign w    = 20'sd65536 - $signed({1'b0, quo_q});
  assign span = (ANG_W + 1)'(m_rad_i) - (ANG_W + 1)'(h_rad_i);

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(w) * PROD_W'(span);
    sunp_q <= sun4_q;
    tilt_o <= h_rad_i + ANG_W'(rnd_shift(64'(prod_q), 16));
    sun_o  <= sunp_q;
  end

endmodule

`default_nettype wire

[sv/kldr_checker.sv]
// Port-level checker for the key-light rotator, bound to the top level.
`default_nettype none
`include "key_light_direction_rotator_macros.svh"

module kldr_checker import kldr_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done_o
);

  localparam int unsigned LAT = LAT_FIXED + CORDIC_STAGES;

  logic acc;
  assign acc = start && !busy;

  `KLDR_ASSERT_IMP(a_result_follows, acc, ##LAT done_o, "transaction without result")
  `KLDR_ASSERT_IMP(a_no_spurious, done_o, $past(acc, LAT), "result without transaction")
  `KLDR_ASSERT_IMP(a_back_to_back, acc ##1 acc, ##LAT done_o, "consecutive results lost")
  `KLDR_ASSERT_NXT(a_never_busy, 1'b1, !busy, "busy raised")

endmodule

bind key_light_direction_rotator kldr_checker #(.CORDIC_STAGES(CORDIC_STAGES)) u_kldr_chk (.*);

`default_nettype wire

[tb/key_light_direction_rotator_tb.sv]
// Self-checking testbench for the key-light direction rotator.
`timescale 1ns / 1ps

module key_light_direction_rotator_tb;
  import kldr_pkg::*;

  // Index outside the register list; the block must drop writes to it.
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 60;

  // Golden model of the rotator plus the queue of directions still owed.
  class dir_scoreboard;
    longint heading_deg, horizon_deg, midday_deg;
    logic signed [15:0] owed_x[$], owed_y[$], owed_z[$];
    int errors;

    function new();
      heading_deg = 0; horizon_deg = 0; midday_deg = 0; errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [16:0] val);
      case (idx)
        CFG_RIG_HEADING:  heading_deg = longint'($signed(val));
        CFG_HORIZON_TILT: horizon_deg = longint'($signed(val[14:0]));
        CFG_MIDDAY_TILT:  midday_deg  = longint'($signed(val[14:0]));
        default: ;
      endcase
    endfunction

    function longint rnd_sh(longint v, int s);
      longint mag;
      mag = (v < 0) ? -v : v;
      if (s > 0) mag = (mag + (64'sd1 <<< (s - 1))) >>> s;
      return (v < 0) ? -mag : mag;
    endfunction

    function longint rnd_div(longint num, longint den);
      longint mag;
      mag = (num < 0) ? -num : num;
      mag = (mag + den / 2) / den;
      return (num < 0) ? -mag : mag;
    endfunction

    function logic signed [15:0] clip16(longint v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
    endfunction

    // Range-reduce, fold into the right half-plane, then run the CORDIC chain.
    task automatic sin_cos(input longint ang, output longint s, output longint c);
      longint t, x, y, z, dx, dy;
      bit flip;
      t = ang % 64'sd6746518852;
      flip = 0;
      x = 64'sd652032874;
      y = 0;
      if (t < 0) t += 64'sd6746518852;
      if (t >= 64'sd3373259426) t -= 64'sd6746518852;
      if (t > 64'sd1686629713) begin
        t -= 64'sd3373259426;
        flip = 1;
      end else if (t < -64'sd1686629713) begin
        t += 64'sd3373259426;
        flip = 1;
      end
      z = t;
      for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
        end else begin
          x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
        end
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
    endtask

    task automatic note_angle(logic [15:0] angle);
      longint a, h, m, rig, d, w, tilt, sa, ca, st, ct, sr, cr, bx, by, ty, tz, rx, rz;
      a = longint'(angle) <<< 17;
      h = rnd_div(horizon_deg * 64'sd3373259426, 23040);
      m = rnd_div(midday_deg * 64'sd3373259426, 23040);
      rig = rnd_div(heading_deg * 64'sd3373259426, 23040);
      d = a - 64'sd1686629713;
      if (d < 0) d = -d;
      // Ramp weight is not clamped: past pi it goes negative and extrapolates.
      w = 65536 - rnd_div(d * 65536, 64'sd1686629713);
      tilt = h + rnd_sh(w * (m - h), 16);
      sin_cos(a, sa, ca);
      sin_cos(tilt, st, ct);
      sin_cos(rig, sr, cr);
      bx = -ca;
      by = -sa;
      ty = rnd_sh(by * ct, 30);
      tz = rnd_sh(-(by * st), 30);
      rx = rnd_sh(bx * cr - tz * sr, 60 - OUT_FRAC_BITS_DEF);
      rz = rnd_sh(bx * sr + tz * cr, 60 - OUT_FRAC_BITS_DEF);
      owed_x.push_back(clip16(rx));
      owed_y.push_back(clip16(rnd_sh(ty, 30 - OUT_FRAC_BITS_DEF)));
      owed_z.push_back(clip16(rz));
    endtask

    task report(string what, logic signed [15:0] got, logic signed [15:0] want);
      errors++;
      $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    endtask

    task check_dir(logic signed [15:0] x, logic signed [15:0] y, logic signed [15:0] z);
      logic signed [15:0] ex, ey, ez;
      if (owed_x.size() == 0) begin
        errors++;
        $display("MISMATCH: unexpected result %0d %0d %0d", x, y, z);
        return;
      end
      ex = owed_x.pop_front();
      ey = owed_y.pop_front();
      ez = owed_z.pop_front();
      if (x !== ex) report("dir_x", x, ex);
      if (y !== ey) report("dir_y", y, ey);
      if (z !== ez) report("dir_z", z, ez);
    endtask

    function int pending();
      return owed_x.size();
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [15:0]        sun_angle_i = '0;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_idx_i = CFG_RIG_HEADING;
  logic [16:0]        cfg_wdata_i = '0;
  logic               done_o;
  logic signed [15:0] dir_x_o, dir_y_o, dir_z_o;

  dir_scoreboard sb = new();
  bit idle_on = 1'b1;

  key_light_direction_rotator dut (
    .clk_i, .rst_ni, .start, .busy, .sun_angle_i,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .done_o, .dir_x_o, .dir_y_o, .dir_z_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Sample everything at the rising edge: register writes, accepted
  // transactions and results all land here, so the model tracks the block.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.write_reg(cfg_idx_i, cfg_wdata_i);
      if (start && !busy) sb.note_angle(sun_angle_i);
      if (done_o) sb.check_dir(dir_x_o, dir_y_o, dir_z_o);
    end
  end

  // Hold start high across back-to-back transactions; drop it only to idle.
  task send_angle(logic [15:0] angle);
    @(negedge clk_i);
    start = 1'b1;
    sun_angle_i = angle;
    do @(posedge clk_i); while (busy);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      start = 1'b0;
      sun_angle_i = 16'($urandom);
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
    end
  endtask

  // Let the pipeline empty; the extra cycles cover the write settling time.
  task drain();
    @(negedge clk_i);
    start = 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (5) @(negedge clk_i);
  endtask

  task write_reg(logic [1:0] idx, logic [16:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    repeat (4) @(negedge clk_i);
  endtask

  task set_regs(logic [16:0] rig, logic [16:0] hor, logic [16:0] mid);
    write_reg(CFG_RIG_HEADING, rig);
    write_reg(CFG_HORIZON_TILT, hor);
    write_reg(CFG_MIDDAY_TILT, mid);
  endtask

  function logic [15:0] rand_angle();
    // Mostly the nominal 0..2*pi range, sometimes any 16-bit value.
    if ($urandom_range(0, 4) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 51471));
  endfunction

  initial begin
    static logic [15:0] corner_angles[14] = '{16'd0, 16'd1, 16'd6434, 16'd12867,
      16'd12868, 16'd12869, 16'd19302, 16'd25735, 16'd25736, 16'd38604, 16'd51471,
      16'd51472, 16'd65535, 16'd32768};
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // Reset configuration: plain base vector sweep.
    foreach (corner_angles[i]) send_angle(corner_angles[i]);
    drain();

    // Extreme headings and tilts, then a dropped write to the unused index.
    set_regs(17'sd46080, -17'sd11520, 17'sd11520);
    write_reg(CFG_UNUSED, 17'h1ffff);
    foreach (corner_angles[i]) if (i < 8) send_angle(corner_angles[i]);
    drain();
    set_regs(-17'sd46080, 17'sd11520, -17'sd11520);
    foreach (corner_angles[i]) if (i >= 6) send_angle(corner_angles[i]);
    drain();

    // Random phases; each starts from a fresh register setting.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_regs(17'd0, 17'd0, 17'd0);
        1: set_regs(17'h1ffff, 17'h07fff, 17'h08000);
        2: set_regs(17'h10000, 17'h18000, 17'h07fff);
        default: set_regs(17'($urandom_range(0, 92160) - 46080),
                          17'($urandom_range(0, 23040) - 11520),
                          17'($urandom_range(0, 23040) - 11520));
      endcase
      if (ph == 4) write_reg(CFG_UNUSED, 17'($urandom));
      idle_on = (ph < 5);
      for (int n = 0; n < 100; n++) begin
        send_angle(rand_angle());
        // Sender hold-off: in phase 1, wait for every owed result mid-phase.
        if (ph == 1 && n == 50) drain();
      end
      drain();
    end

    while (sb.pending() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Verification failed");
    $finish;
  end

endmodule
